FILE: sv/erc_pkg.sv
`default_nettype none
package erc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 16;
    localparam int GAIN_SHIFT  = 16;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 8;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLICK  = 2'd1;
    localparam logic [1:0] CMD_HOLD   = 2'd2;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_EX_START  = 3'd1;
    localparam logic [2:0] EV_SER_START = 3'd2;
    localparam logic [2:0] EV_SAMPLE    = 3'd3;
    localparam logic [2:0] EV_REP       = 3'd4;
    localparam logic [2:0] EV_SER_END   = 3'd5;
    localparam logic [2:0] EV_EX_END    = 3'd6;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ON    = 2'd1;
    localparam logic [1:0] LED_BLINK = 2'd2;

    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_START_THR = 2'd1;
    localparam logic [1:0] REG_END_THR   = 2'd2;
    localparam logic [1:0] REG_MIN_DUR   = 2'd3;

    localparam logic [CFG_W-1:0] GAIN_RST      = 16'd6554;
    localparam logic [CFG_W-1:0] START_THR_RST = 16'd819;
    localparam logic [CFG_W-1:0] END_THR_RST   = 16'd41;
    localparam logic [CFG_W-1:0] MIN_DUR_RST   = 16'd500;

    typedef struct packed {
        logic        [CFG_W-1:0] gain;
        logic signed [CFG_W-1:0] start_thr;
        logic signed [CFG_W-1:0] end_thr;
        logic        [CFG_W-1:0] min_dur;
    } t_cfg;

    typedef struct packed {
        logic        [2:0]             event_code;
        logic        [1:0]             led_mode;
        logic        [CNT_W-1:0]       rep_number;
        logic        [CNT_W-1:0]       series_number;
        logic signed [SAMPLE_BITS-1:0] smoothed_out;
        logic                          measuring_flag;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/erc_in_if.sv
`default_nettype none
interface erc_in_if import erc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic        [1:0]             cmd;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic        [TIME_W-1:0]      now_ms;

    modport source (output valid, cmd, sample_y, now_ms, input ready);
    modport sink (input valid, cmd, sample_y, now_ms, output ready);
endinterface
`default_nettype wire

FILE: sv/erc_out_if.sv
`default_nettype none
interface erc_out_if import erc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic        [2:0]             event_code;
    logic        [1:0]             led_mode;
    logic        [CNT_W-1:0]       rep_number;
    logic        [CNT_W-1:0]       series_number;
    logic signed [SAMPLE_BITS-1:0] smoothed_out;
    logic                          measuring_flag;

    modport source (output valid, event_code, led_mode, rep_number, series_number,
                    smoothed_out, measuring_flag, input ready);
    modport sink (input valid, event_code, led_mode, rep_number, series_number,
                  smoothed_out, measuring_flag, output ready);
endinterface
`default_nettype wire

FILE: sv/erc_ema.sv
`default_nettype none
module erc_ema import erc_pkg::*; (
    input  wire logic        [CFG_W-1:0]       i_gain,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_level,
    output logic signed      [SAMPLE_BITS-1:0] o_level
);

    logic signed [SAMPLE_BITS:0]                  diff;
    logic signed [SAMPLE_BITS+CFG_W+1:0]          prod;
    logic signed [SAMPLE_BITS+CFG_W+1-GAIN_SHIFT:0] step;
    logic signed [SAMPLE_BITS+CFG_W+1-GAIN_SHIFT:0] sum;

    // The arithmetic shift of the product rounds toward minus infinity.
    assign diff = {i_sample[SAMPLE_BITS-1], i_sample} - {i_level[SAMPLE_BITS-1], i_level};
    assign prod = $signed({1'b0, i_gain}) * diff;
    assign step = prod[SAMPLE_BITS+CFG_W+1:GAIN_SHIFT];
    assign sum  = {{(CFG_W+2-GAIN_SHIFT){i_level[SAMPLE_BITS-1]}}, i_level} + step;
    assign o_level = sum[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

FILE: sv/erc_core.sv
`default_nettype none
module erc_core import erc_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic        [1:0]             i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic        [TIME_W-1:0]      i_now,
    input  wire t_cfg                          i_cfg,
    output t_result                            o_res
);

    logic                          r_measuring, n_measuring;
    logic                          r_fresh, n_fresh;
    logic                          r_active, n_active;
    logic        [CNT_W-1:0]       r_rep, n_rep;
    logic        [CNT_W-1:0]       r_series, n_series;
    logic                          r_moving, n_moving;
    logic        [TIME_W-1:0]      r_move_start, n_move_start;
    logic signed [SAMPLE_BITS-1:0] r_level, n_level;
    logic        [1:0]             r_led, n_led;
    logic signed [SAMPLE_BITS-1:0] filt_level;
    logic        [TIME_W-1:0]      dur;
    logic        [2:0]             ev;

    erc_ema u_ema (
        .i_gain   (i_cfg.gain),
        .i_sample (i_sample),
        .i_level  (r_level),
        .o_level  (filt_level)
    );

    assign dur = i_now - r_move_start;

    always_comb begin
        n_measuring  = r_measuring;
        n_fresh      = r_fresh;
        n_active     = r_active;
        n_rep        = r_rep;
        n_series     = r_series;
        n_moving     = r_moving;
        n_move_start = r_move_start;
        n_level      = r_level;
        n_led        = r_led;
        ev           = EV_NONE;
        case (i_cmd)
            CMD_SAMPLE: begin
                if (r_measuring) begin
                    n_level = filt_level;
                    ev      = EV_SAMPLE;
                    if (!r_moving && (filt_level > i_cfg.start_thr)) begin
                        n_moving     = 1'b1;
                        n_move_start = i_now;
                    end else if (r_moving && (filt_level < i_cfg.end_thr)) begin
                        n_moving = 1'b0;
                        if (dur > {{(TIME_W-CFG_W){1'b0}}, i_cfg.min_dur}) begin
                            n_rep = r_rep + 1'b1;
                            ev    = EV_REP;
                        end
                    end
                end
            end
            CMD_CLICK: begin
                if (r_active) begin
                    if (!r_measuring) begin
                        n_measuring = 1'b1;
                        n_led       = LED_ON;
                        n_series    = r_series + 1'b1;
                        ev          = EV_SER_START;
                    end else begin
                        n_measuring = 1'b0;
                        n_led       = LED_BLINK;
                        n_rep       = '0;
                        ev          = EV_SER_END;
                    end
                end
            end
            CMD_HOLD: begin
                if (r_fresh) begin
                    n_fresh  = 1'b0;
                    n_active = 1'b1;
                    n_led    = LED_BLINK;
                    ev       = EV_EX_START;
                end else begin
                    n_measuring = 1'b0;
                    n_fresh     = 1'b1;
                    n_active    = 1'b0;
                    n_led       = LED_OFF;
                    n_series    = '0;
                    ev          = EV_EX_END;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring  <= 1'b0;
            r_fresh      <= 1'b1;
            r_active     <= 1'b0;
            r_rep        <= '0;
            r_series     <= '0;
            r_moving     <= 1'b0;
            r_move_start <= '0;
            r_level      <= '0;
            r_led        <= LED_OFF;
        end else if (i_step) begin
            r_measuring  <= n_measuring;
            r_fresh      <= n_fresh;
            r_active     <= n_active;
            r_rep        <= n_rep;
            r_series     <= n_series;
            r_moving     <= n_moving;
            r_move_start <= n_move_start;
            r_level      <= n_level;
            r_led        <= n_led;
        end
    end

    assign o_res.event_code     = ev;
    assign o_res.led_mode       = n_led;
    assign o_res.rep_number     = n_rep;
    assign o_res.series_number  = n_series;
    assign o_res.smoothed_out   = n_level;
    assign o_res.measuring_flag = n_measuring;

endmodule
`default_nettype wire

FILE: sv/exercise_rep_counter_unit.sv
// Channel   Direction  Payload
// i_item    in         cmd, sample_y, now_ms
// o_result  out        event_code, led_mode, rep_number, series_number,
//                      smoothed_out, measuring_flag
// i_cfg_*   in         write enable, register index, 16-bit data
//
// Each item is captured in the input register and then moves to the result register;
// one item is taken per cycle while the result register is not stalled.
// The filter multiply and threshold compares sit between those two registers.
// A stalled result register holds the input register, which then holds i_item.ready low.
// Reset is synchronous and returns the valid flags, the settings and the counter state
// to their defaults.
`default_nettype none
module exercise_rep_counter_unit import erc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    erc_in_if.sink                 i_item,
    erc_out_if.source              o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg                          r_cfg;
    logic                          r_in_valid;
    logic        [1:0]             r_cmd;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic        [TIME_W-1:0]      r_now;
    logic                          r_out_valid;
    t_result                       r_out;
    t_result                       res;
    logic                          step;
    logic                          take;

    assign step = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || step;
    assign take = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain      <= GAIN_RST;
            r_cfg.start_thr <= START_THR_RST;
            r_cfg.end_thr   <= END_THR_RST;
            r_cfg.min_dur   <= MIN_DUR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN:      r_cfg.gain      <= i_cfg_data;
                REG_START_THR: r_cfg.start_thr <= i_cfg_data;
                REG_END_THR:   r_cfg.end_thr   <= i_cfg_data;
                REG_MIN_DUR:   r_cfg.min_dur   <= i_cfg_data;
                default:       r_cfg.gain      <= r_cfg.gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd    <= i_item.cmd;
            r_sample <= i_item.sample_y;
            r_now    <= i_item.now_ms;
        end
        if (step) begin
            r_out <= res;
        end
    end

    erc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (r_cmd),
        .i_sample (r_sample),
        .i_now    (r_now),
        .i_cfg    (r_cfg),
        .o_res    (res)
    );

    assign o_result.valid          = r_out_valid;
    assign o_result.event_code     = r_out.event_code;
    assign o_result.led_mode       = r_out.led_mode;
    assign o_result.rep_number     = r_out.rep_number;
    assign o_result.series_number  = r_out.series_number;
    assign o_result.smoothed_out   = r_out.smoothed_out;
    assign o_result.measuring_flag = r_out.measuring_flag;

endmodule
`default_nettype wire

FILE: sv/erc_checker.sv
`default_nettype none
module erc_checker import erc_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [2:0]             i_event_code,
    input wire logic [1:0]             i_led_mode,
    input wire logic [CNT_W-1:0]       i_rep_number,
    input wire logic [CNT_W-1:0]       i_series_number,
    input wire logic [SAMPLE_BITS-1:0] i_smoothed_out,
    input wire logic                   i_measuring_flag
);

    // A stalled result stays valid and keeps its event code, rep number and smoothed output.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_code)
            && $stable(i_rep_number) && $stable(i_smoothed_out))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ser_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_code == EV_SER_START)
            |-> i_measuring_flag && (i_led_mode == LED_ON))
        else $error("series start without measuring");

    a_ser_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_code == EV_SER_END)
            |-> !i_measuring_flag && (i_rep_number == '0) && (i_led_mode == LED_BLINK))
        else $error("series end left state behind");

    a_ex_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_code == EV_EX_END)
            |-> !i_measuring_flag && (i_series_number == '0) && (i_led_mode == LED_OFF))
        else $error("exercise end left state behind");

endmodule

bind exercise_rep_counter_unit erc_checker u_erc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_event_code     (o_result.event_code),
    .i_led_mode       (o_result.led_mode),
    .i_rep_number     (o_result.rep_number),
    .i_series_number  (o_result.series_number),
    .i_smoothed_out   (o_result.smoothed_out),
    .i_measuring_flag (o_result.measuring_flag)
);
`default_nettype wire
